FILE: sv/fixed_pool_free_list_allocator_assert.svh
// Assertion macros for the free list allocator.
// Active in simulation; empty when SYNTHESIS is defined.
`ifndef FIXED_POOL_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FIXED_POOL_FREE_LIST_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

`define FPFL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("allocator assertion failed");

`define FPFL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("allocator assertion failed");

`else

`define FPFL_ASSERT_IMP(lbl, ante, cons)
`define FPFL_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

FILE: sv/fpfl_pkg.sv
// Shared codes and field widths for the free list allocator.
// No dependencies.
package fpfl_pkg;

    localparam int IDX_W    = 8;
    localparam int BUSY_W   = 9;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;

    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESET = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_FREE_IDLE = 2'd2
    } t_status;

endpackage

FILE: sv/fpfl_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module fpfl_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/fixed_pool_free_list_allocator.sv
// Free list allocator top level: request decode, stack state, result register.
// Depends on fpfl_pkg, fpfl_ram and fixed_pool_free_list_allocator_assert.svh.
//
// Usage:
//   Requests enter on the slave stream: tuser[1:0] is the kind (allocate,
//   free, reset pool), tdata[7:0] the node index to free. Each request
//   gives exactly one result on the master stream: tuser[1:0] status,
//   tdata[7:0] granted index, tdata[16:8] busy count after the request.
//   A request is decided in the cycle it is taken and its result is held
//   in the output register from the next cycle: throughput one request
//   per cycle while the receiver takes each result. The free stack links
//   live in a POOL_NODES entry RAM; the link of the stack head is
//   prefetched ahead (or forwarded right after a free), so back-to-back
//   pops never wait on the RAM read.
//   While the result waits, a new request is taken only in a cycle where
//   the receiver takes the old one; a stall holds the result and the
//   slave ready stays low.
//   After i_rst_n the stack is empty, no node is busy and allocation
//   starts at index 0. The RAM is not cleared; entries are read only
//   after a free has written them.
module fixed_pool_free_list_allocator
    import fpfl_pkg::*;
#(
    parameter int POOL_NODES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] node_index
    input  logic [1:0]  i_s_tuser,   // [1:0] kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [7:0] granted_index, [16:8] busy_count
    output logic [1:0]  o_m_tuser    // [1:0] status
);

`include "fixed_pool_free_list_allocator_assert.svh"

    localparam int IW = $clog2(POOL_NODES);
    localparam int BW = $clog2(POOL_NODES + 1);

    logic [IW-1:0]       r_head, n_head;
    logic                r_head_vld, n_head_vld;
    logic [BW-1:0]       r_fresh, n_fresh;
    logic [BW-1:0]       r_busy, n_busy;
    logic                r_fwd, n_fwd;
    logic [IW:0]         r_fwd_link;
    logic                r_out_vld;
    logic [IDX_W-1:0]    r_out_grant;
    t_status             r_out_status;
    logic [BUSY_W-1:0]   r_out_busy;

    logic                accept;
    logic [IW:0]         ram_rd_data;
    logic [IW:0]         head_link;
    logic                wr_en;
    logic [IW:0]         wr_data;
    logic [IW+7:0]       idx_ext;
    logic [IW-1:0]       idx;
    logic                idx_in_range;
    logic [IW-1:0]       grant;
    t_status             status;
    logic [IW+7:0]       grant_ext;
    logic [BW+8:0]       busy_ext;
    logic                alloc_ok;

    assign o_s_tready   = !r_out_vld || i_m_tready;
    assign accept       = i_s_tvalid && o_s_tready;
    assign idx_ext      = {{IW{1'b0}}, i_s_tdata};
    assign idx          = idx_ext[IW-1:0];
    assign idx_in_range = idx_ext < (IW+8)'(POOL_NODES);
    assign head_link    = r_fwd ? r_fwd_link : ram_rd_data;
    assign wr_data      = {r_head_vld, r_head};

    always_comb begin
        n_head     = r_head;
        n_head_vld = r_head_vld;
        n_fresh    = r_fresh;
        n_busy     = r_busy;
        n_fwd      = 1'b0;
        wr_en      = 1'b0;
        grant      = '0;
        status     = ST_OK;
        if (accept) begin
            case (i_s_tuser)
                KIND_ALLOC: begin
                    if (r_busy >= BW'(POOL_NODES)) begin
                        status = ST_EXHAUSTED;
                    end else if (r_head_vld) begin
                        grant      = r_head;
                        n_head     = head_link[IW-1:0];
                        n_head_vld = head_link[IW];
                        n_busy     = r_busy + BW'(1);
                    end else if (r_fresh < BW'(POOL_NODES)) begin
                        grant   = r_fresh[IW-1:0];
                        n_fresh = r_fresh + BW'(1);
                        n_busy  = r_busy + BW'(1);
                    end else begin
                        status = ST_EXHAUSTED;
                    end
                end
                KIND_FREE: begin
                    if (r_busy == '0) begin
                        status = ST_FREE_IDLE;
                    end else if (idx_in_range) begin
                        wr_en      = 1'b1;
                        n_head     = idx;
                        n_head_vld = 1'b1;
                        n_busy     = r_busy - BW'(1);
                        n_fwd      = 1'b1;
                    end
                end
                KIND_RESET: begin
                    n_head     = '0;
                    n_head_vld = 1'b0;
                    n_fresh    = '0;
                    n_busy     = '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign grant_ext = {8'b0, grant};
    assign busy_ext  = {9'b0, n_busy};
    assign alloc_ok  = accept && i_s_tuser == KIND_ALLOC && status == ST_OK;

    fpfl_ram #(
        .WIDTH (IW + 1),
        .DEPTH (POOL_NODES)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (idx),
        .i_wr_data (wr_data),
        .i_rd_addr (n_head),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_head_vld <= 1'b0;
            r_fresh    <= '0;
            r_busy     <= '0;
            r_fwd      <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_head     <= n_head;
            r_head_vld <= n_head_vld;
            r_fresh    <= n_fresh;
            r_busy     <= n_busy;
            r_fwd      <= n_fwd;
            if (accept) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_fwd) begin
            r_fwd_link <= wr_data;
        end
        if (accept) begin
            r_out_grant  <= grant_ext[7:0];
            r_out_status <= status;
            r_out_busy   <= busy_ext[8:0];
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {7'b0, r_out_busy, r_out_grant};
    assign o_m_tuser  = r_out_status;

    `FPFL_ASSERT_IMP(a_busy_range, 1'b1, r_busy <= BW'(POOL_NODES))
    `FPFL_ASSERT_IMP(a_fresh_range, 1'b1, r_fresh <= BW'(POOL_NODES))
    `FPFL_ASSERT_NXT(a_alloc_count, alloc_ok, r_busy == $past(r_busy) + BW'(1))
    `FPFL_ASSERT_NXT(a_fwd_after_push, wr_en, r_fwd && r_head_vld)

endmodule

FILE: tb/fixed_pool_free_list_allocator_checker.sv
// Checker for the free list allocator: predicts each result from the request stream
// and compares it with the master stream. Depends on fpfl_pkg.
module fixed_pool_free_list_allocator_checker
    import fpfl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] node_index
    input  logic [1:0]  i_s_tuser,   // [1:0] kind
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,   // [7:0] granted_index, [16:8] busy_count
    input  logic [1:0]  i_m_tuser,   // [1:0] status
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES = 256;

    typedef struct packed {
        logic [IDX_W-1:0]  granted;
        t_status           status;
        logic [BUSY_W-1:0] busy;
    } t_grant;

    // link entry: [8] next valid, [7:0] next node
    logic [BUSY_W-1:0] link_mem [NODES];
    logic [IDX_W-1:0]  stack_top;
    logic              stack_live;
    logic [BUSY_W-1:0] fresh_next;
    logic [BUSY_W-1:0] busy_cnt;
    t_grant            grant_q [$];

    task automatic clear_pool();
        stack_top  = '0;
        stack_live = 1'b0;
        fresh_next = '0;
        busy_cnt   = '0;
    endtask

    task automatic serve_request(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx,
                                 output t_grant res);
        logic [BUSY_W-1:0] nxt;
        res = '{granted: '0, status: ST_OK, busy: '0};
        case (kind)
            KIND_ALLOC: begin
                if (busy_cnt >= NODES) begin
                    res.status = ST_EXHAUSTED;
                end else if (stack_live) begin
                    res.granted = stack_top;
                    nxt         = link_mem[stack_top];
                    stack_live  = nxt[8];
                    stack_top   = nxt[7:0];
                    busy_cnt++;
                end else if (fresh_next < NODES) begin
                    res.granted = fresh_next[IDX_W-1:0];
                    fresh_next++;
                    busy_cnt++;
                end else begin
                    res.status = ST_EXHAUSTED;
                end
            end
            KIND_FREE: begin
                if (busy_cnt == 0) begin
                    res.status = ST_FREE_IDLE;
                end else begin
                    link_mem[idx] = {stack_live, stack_top};
                    stack_top     = idx;
                    stack_live    = 1'b1;
                    busy_cnt--;
                end
            end
            KIND_RESET: begin
                clear_pool();
            end
            default: ;
        endcase
        res.busy = busy_cnt;
    endtask

    always @(posedge i_clk) begin
        t_grant got;
        t_grant want;
        t_grant res;
        if (!i_rst_n) begin
            clear_pool();
            grant_q.delete();
            o_fail_count = 0;
            o_pending <= 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = {i_m_tdata[7:0], t_status'(i_m_tuser), i_m_tdata[16:8]};
                if (grant_q.size() == 0) begin
                    $error("unexpected result transaction: granted_index %0d status %0d busy %0d",
                           got.granted, got.status, got.busy);
                    o_fail_count++;
                end else begin
                    want = grant_q.pop_front();
                    if (got.granted !== want.granted) begin
                        $error("granted_index: expected %0d, actual %0d",
                               want.granted, got.granted);
                        o_fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        o_fail_count++;
                    end
                    if (got.busy !== want.busy) begin
                        $error("busy_count: expected %0d, actual %0d", want.busy, got.busy);
                        o_fail_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                serve_request(i_s_tuser, i_s_tdata, res);
                grant_q.push_back(res);
            end
            o_pending <= grant_q.size();
        end
    end

endmodule

FILE: tb/fixed_pool_free_list_allocator_tb.sv
// Testbench top for the free list allocator: clock, reset, request and stall stimulus,
// verdict. Depends on fpfl_pkg, the allocator RTL and the allocator checker.
module fixed_pool_free_list_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fpfl_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1200;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [7:0]  i_s_tdata  = '0;
    logic [1:0]  i_s_tuser  = KIND_ALLOC;
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [23:0] o_m_tdata;
    logic [1:0]  o_m_tuser;

    int fail_count;
    int pending;
    int burst_left  = 0;
    int sent_total  = 0;
    int ready_tick  = 0;
    int stall_left  = 0;
    int fill_rounds = 0;

    fixed_pool_free_list_allocator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    fixed_pool_free_list_allocator_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: always ready, random ready, then long stalls, rotating
    always @(posedge i_clk) begin
        ready_tick++;
        case ((ready_tick / 300) % 3)
            0: i_m_tready <= 1'b1;
            1: i_m_tready <= ($urandom_range(0, 3) != 0);
            default: begin
                if (stall_left != 0) begin
                    stall_left--;
                    i_m_tready <= 1'b0;
                end else begin
                    i_m_tready <= 1'b1;
                    if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 12);
                end
            end
        endcase
    end

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= idx;
        i_s_tuser  <= kind;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        burst_left--;
        sent_total++;
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // exhaust the pool, build a deep free stack, pop it back
    task automatic fill_and_unwind();
        int n;
        drain();
        send_item(KIND_RESET, 8'($urandom_range(0, 255)));
        n = $urandom_range(256, 260);
        repeat (n) send_item(KIND_ALLOC, 8'($urandom_range(0, 255)));
        n = $urandom_range(20, 120);
        repeat (n) send_item(KIND_FREE, 8'($urandom_range(0, 255)));
        n = $urandom_range(20, 130);
        repeat (n) send_item(KIND_ALLOC, 8'($urandom_range(0, 255)));
        fill_rounds++;
    endtask

    task automatic mixed_burst();
        int n;
        int r;
        logic [KIND_W-1:0] kind;
        n = $urandom_range(8, 40);
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 55)      kind = KIND_ALLOC;
            else if (r < 94) kind = KIND_FREE;
            else if (r < 97) kind = KIND_RESET;
            else             kind = KIND_UNUSED;
            send_item(kind, 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int start_count;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(KIND_ALLOC, 8'd0);
        send_item(KIND_ALLOC, 8'd255);
        send_item(KIND_ALLOC, 8'd0);
        send_item(KIND_FREE, 8'd255);
        send_item(KIND_FREE, 8'd0);
        send_item(KIND_FREE, 8'd0);        // double free
        send_item(KIND_FREE, 8'd7);        // nothing busy
        send_item(KIND_ALLOC, 8'd0);
        send_item(KIND_ALLOC, 8'd0);
        send_item(KIND_ALLOC, 8'd0);
        send_item(KIND_ALLOC, 8'd255);
        send_item(KIND_UNUSED, 8'd255);
        send_item(KIND_RESET, 8'd170);
        send_item(KIND_FREE, 8'd0);
        send_item(KIND_UNUSED, 8'd85);
        send_item(KIND_ALLOC, 8'd255);
        send_item(KIND_FREE, 8'd0);
        send_item(KIND_ALLOC, 8'd0);
        send_item(KIND_ALLOC, 8'd0);
        drain();

        start_count = sent_total;
        fill_and_unwind();
        while (sent_total - start_count < RANDOM_ITEMS) begin
            if (fill_rounds < 2 && $urandom_range(0, 99) < 4) fill_and_unwind();
            else if ($urandom_range(0, 99) < 5) drain();
            else mixed_burst();
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/fpfl_pkg.sv
sv/fpfl_ram.sv
sv/fixed_pool_free_list_allocator.sv
tb/fixed_pool_free_list_allocator_checker.sv
tb/fixed_pool_free_list_allocator_tb.sv
